// ===== rtl/core/gar_pkg.sv =====
// Shared types, constants and register codes for the gamepad autorepeat qualifier.
package gar_pkg;

    localparam int unsigned BTN_W    = 24;
    localparam int unsigned AXIS_W   = 8;
    localparam int unsigned FRAME_W  = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned IN_DATA_W = BTN_W + 2 * AXIS_W + FRAME_W;

    // Direction bits merged into the button word
    localparam logic [BTN_W-1:0] DIR_UP    = 24'h000010;
    localparam logic [BTN_W-1:0] DIR_RIGHT = 24'h000020;
    localparam logic [BTN_W-1:0] DIR_DOWN  = 24'h000040;
    localparam logic [BTN_W-1:0] DIR_LEFT  = 24'h000080;

    // Action codes carried in tuser
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BUTTON_MASK    = 3'd0,
        REG_LOW_THRESHOLD  = 3'd1,
        REG_HIGH_THRESHOLD = 3'd2,
        REG_INITIAL_DELAY  = 3'd3,
        REG_DELAY_STEP     = 3'd4,
        REG_DELAY_FLOOR    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [BTN_W-1:0]   button_mask;
        logic [AXIS_W-1:0]  low_threshold;
        logic [AXIS_W-1:0]  high_threshold;
        logic [FRAME_W-1:0] initial_delay;
        logic [FRAME_W-1:0] delay_step;
        logic [FRAME_W-1:0] delay_floor;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        button_mask:    24'hFFFFFF,
        low_threshold:  8'd48,
        high_threshold: 8'd208,
        initial_delay:  8'd8,
        delay_step:     8'd2,
        delay_floor:    8'd2
    };

    // One sample as held in the input stage
    typedef struct packed {
        logic               action;
        logic [BTN_W-1:0]   raw_buttons;
        logic [AXIS_W-1:0]  stick_x;
        logic [AXIS_W-1:0]  stick_y;
        logic [FRAME_W-1:0] elapsed_frames;
    } sample_t;

endpackage

// ===== rtl/core/gar_cfg_regs.sv =====
// Configuration register file of the autorepeat qualifier.
module gar_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [gar_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [gar_pkg::BTN_W-1:0]      wr_data,
    output gar_pkg::cfg_t                  cfg
);

    gar_pkg::cfg_t cfg_reg;
    gar_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (gar_pkg::cfg_reg_t'(wr_index))
                gar_pkg::REG_BUTTON_MASK:    cfg_next.button_mask    = wr_data;
                gar_pkg::REG_LOW_THRESHOLD:  cfg_next.low_threshold  = wr_data[7:0];
                gar_pkg::REG_HIGH_THRESHOLD: cfg_next.high_threshold = wr_data[7:0];
                gar_pkg::REG_INITIAL_DELAY:  cfg_next.initial_delay  = wr_data[7:0];
                gar_pkg::REG_DELAY_STEP:     cfg_next.delay_step     = wr_data[7:0];
                gar_pkg::REG_DELAY_FLOOR:    cfg_next.delay_floor    = wr_data[7:0];
                default:                     cfg_next = cfg_reg; // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= gar_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/gar_merge.sv =====
// Button masking and stick-to-direction merge.
module gar_merge
(
    input  gar_pkg::cfg_t                 cfg,
    input  logic [gar_pkg::BTN_W-1:0]     raw_buttons,
    input  logic [gar_pkg::AXIS_W-1:0]    stick_x,
    input  logic [gar_pkg::AXIS_W-1:0]    stick_y,
    output logic [gar_pkg::BTN_W-1:0]     merged
);

    always_comb
    begin
        merged = raw_buttons & cfg.button_mask;
        if (stick_y >= cfg.high_threshold) merged = merged | gar_pkg::DIR_DOWN;
        if (stick_y <= cfg.low_threshold)  merged = merged | gar_pkg::DIR_UP;
        if (stick_x <= cfg.low_threshold)  merged = merged | gar_pkg::DIR_LEFT;
        if (stick_x >= cfg.high_threshold) merged = merged | gar_pkg::DIR_RIGHT;
    end

endmodule

// ===== rtl/core/gar_repeat.sv =====
// Held tracking, frame counter and shrinking repeat delay.
module gar_repeat
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          update,
    input  logic                          action,
    input  logic [gar_pkg::BTN_W-1:0]     merged,
    input  logic [gar_pkg::FRAME_W-1:0]   elapsed_frames,
    input  gar_pkg::cfg_t                 cfg,
    output logic [gar_pkg::BTN_W-1:0]     pad_state
);

    logic                         held_reg;
    logic                         held_next;
    logic [gar_pkg::FRAME_W-1:0]  count_reg;
    logic [gar_pkg::FRAME_W-1:0]  count_next;
    logic [gar_pkg::FRAME_W-1:0]  delay_reg;
    logic [gar_pkg::FRAME_W-1:0]  delay_next;
    logic [gar_pkg::FRAME_W-1:0]  count_sum;

    assign count_sum = count_reg + elapsed_frames; // wraps mod 256

    always_comb
    begin
        held_next  = held_reg;
        count_next = count_reg;
        delay_next = delay_reg;
        pad_state  = '0;
        if (action == gar_pkg::ACT_CLEAR)
        begin
            held_next = 1'b0;
        end
        else if (merged == '0)
        begin
            held_next = 1'b0;
        end
        else if (!held_reg)
        begin
            // fresh press
            held_next  = 1'b1;
            count_next = '0;
            delay_next = cfg.initial_delay;
            pad_state  = merged;
        end
        else if (count_sum > delay_reg)
        begin
            count_next = '0;
            pad_state  = merged;
            if (delay_reg > cfg.delay_floor)
            begin
                delay_next = (delay_reg > cfg.delay_step) ? (delay_reg - cfg.delay_step) : '0;
            end
        end
        else
        begin
            count_next = count_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 1'b0;
            count_reg <= '0;
            delay_reg <= '0;
        end
        else if (update)
        begin
            held_reg  <= held_next;
            count_reg <= count_next;
            delay_reg <= delay_next;
        end
    end

endmodule

// ===== rtl/core/gamepad_autorepeat_qualifier.sv =====
// Top level of the gamepad autorepeat qualifier: input stage, qualify logic, result stage.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------------------
//  s_*     | in  | s_tvalid / s_tready   | s_tdata: buttons, stick x/y, elapsed; s_tuser
//  m_*     | out | m_tvalid / m_tready   | m_tdata: pad_state
//  cfg_*   | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One sample per cycle sustained while m_tready keeps up; a result passes through the input
// register, then the result register, with the qualify logic between them.
// Repeat state advances when a sample moves from the input register into the
// result register, so samples are qualified strictly in order.
// A stalled result holds the result register; the input register can still take a sample,
// and s_tready drops only when both stages are full and m_tready is low.
// rst_n clears valids, repeat state and loads the register defaults; cfg_ready is always high.
module gamepad_autorepeat_qualifier
(
    input  logic                               clk,
    input  logic                               rst_n,
    // sample stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [23:0] raw_buttons, [31:24] stick_x, [39:32] stick_y, [47:40] elapsed_frames
    input  logic [gar_pkg::IN_DATA_W-1:0]      s_tdata,
    // [0] action (1 = clear repeat state)
    input  logic                               s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [23:0] pad_state
    output logic [gar_pkg::BTN_W-1:0]          m_tdata,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gar_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gar_pkg::BTN_W-1:0]          cfg_data
);

    gar_pkg::cfg_t                 cfg;
    gar_pkg::sample_t              in_reg;
    logic                          in_valid_reg;
    logic                          out_valid_reg;
    logic [gar_pkg::BTN_W-1:0]     out_data_reg;
    logic                          out_adv;
    logic                          in_take;
    logic                          in_move;
    logic [gar_pkg::BTN_W-1:0]     merged;
    logic [gar_pkg::BTN_W-1:0]     pad_state;

    assign cfg_ready = 1'b1;

    gar_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Handshake: result register frees when empty or taken
    assign out_adv  = !out_valid_reg || m_tready;
    assign in_move  = in_valid_reg && out_adv;
    assign s_tready = !in_valid_reg || out_adv;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_adv)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg.action         <= s_tuser;
            in_reg.raw_buttons    <= s_tdata[23:0];
            in_reg.stick_x        <= s_tdata[31:24];
            in_reg.stick_y        <= s_tdata[39:32];
            in_reg.elapsed_frames <= s_tdata[47:40];
        end
        if (in_move)
        begin
            out_data_reg <= pad_state;
        end
    end

    gar_merge u_merge
    (
        .cfg         (cfg),
        .raw_buttons (in_reg.raw_buttons),
        .stick_x     (in_reg.stick_x),
        .stick_y     (in_reg.stick_y),
        .merged      (merged)
    );

    gar_repeat u_repeat
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .update         (in_move),
        .action         (in_reg.action),
        .merged         (merged),
        .elapsed_frames (in_reg.elapsed_frames),
        .cfg            (cfg),
        .pad_state      (pad_state)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/core/gar_checker.sv =====
// Port-level checks for the gamepad autorepeat qualifier, bound to the top level.
module gar_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [gar_pkg::BTN_W-1:0]      m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side blocks only behind a stalled, full result
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

    // result shows up after a transfer when the output side is free
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
        else $error("result missing two cycles after transfer");

    // a clear transfer yields an all-zero result
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) ##1 m_tready |=> m_tdata == '0)
        else $error("clear did not give zero result");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind gamepad_autorepeat_qualifier gar_checker u_gar_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/gamepad_autorepeat_qualifier_tb.sv =====
// Self-checking testbench for the gamepad autorepeat qualifier.
module gamepad_autorepeat_qualifier_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int LONG_STALL    = 80;     // receiver hold-off, in cycles
    localparam int ITEMS_PER_SET = 130;    // random samples per register setting
    localparam int DRAIN_CYCLES  = 8;      // two pipeline stages plus margin

    typedef logic [gar_pkg::BTN_W-1:0] btn_t;

    // One row of the directed table: either a register write or a sample.
    typedef struct {
        bit                         is_write;
        gar_pkg::cfg_reg_t          reg_sel;
        logic [gar_pkg::BTN_W-1:0]  reg_val;
        gar_pkg::sample_t           smp;
        bit                         known;      // pad value typed into the table
        logic [gar_pkg::BTN_W-1:0]  pad;
    } stim_row_t;

    logic                               clk;
    logic                               rst_n = 1'b0;

    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    // [23:0] raw_buttons, [31:24] stick_x, [39:32] stick_y, [47:40] elapsed_frames
    logic [gar_pkg::IN_DATA_W-1:0]      s_tdata = '0;
    // [0] action
    logic                               s_tuser = 1'b0;

    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    // [23:0] pad_state
    logic [gar_pkg::BTN_W-1:0]          m_tdata;

    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [gar_pkg::CFG_IDX_W-1:0]      cfg_index = gar_pkg::REG_BUTTON_MASK;
    logic [gar_pkg::BTN_W-1:0]          cfg_data = '0;

    // Predictor state: register image plus repeat tracking
    gar_pkg::cfg_t                      cfg_image = gar_pkg::CFG_RESET;
    bit                                 rep_held = 1'b0;
    logic [gar_pkg::FRAME_W-1:0]        rep_count = '0;
    logic [gar_pkg::FRAME_W-1:0]        rep_delay = '0;

    logic [gar_pkg::BTN_W-1:0]          expected_pad[$];
    logic [gar_pkg::BTN_W-1:0]          pad_want;
    stim_row_t                          directed_rows[$];

    int                     errors = 0;
    int                     cycles = 0;
    int                     samples_sent = 0;
    int                     pads_checked = 0;
    int                     settings_applied = 0;
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    int                     stall_requests = 0;
    int                     stall_served = 0;

    gamepad_autorepeat_qualifier dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Qualify one sample against the register image; advances repeat state.
    function automatic logic [gar_pkg::BTN_W-1:0] qualify_sample(gar_pkg::sample_t smp);
        logic [gar_pkg::BTN_W-1:0] merged;
        if (smp.action == gar_pkg::ACT_CLEAR)
        begin
            // clear: drop held mark, leave count and delay alone
            rep_held = 1'b0;
            return '0;
        end
        merged = smp.raw_buttons & cfg_image.button_mask;
        if (smp.stick_y >= cfg_image.high_threshold) merged |= gar_pkg::DIR_DOWN;
        if (smp.stick_y <= cfg_image.low_threshold)  merged |= gar_pkg::DIR_UP;
        if (smp.stick_x <= cfg_image.low_threshold)  merged |= gar_pkg::DIR_LEFT;
        if (smp.stick_x >= cfg_image.high_threshold) merged |= gar_pkg::DIR_RIGHT;
        if (merged == '0)
        begin
            rep_held = 1'b0;
            return '0;
        end
        if (!rep_held)
        begin
            // fresh press passes at once, elapsed frames ignored
            rep_held  = 1'b1;
            rep_count = '0;
            rep_delay = cfg_image.initial_delay;
            return merged;
        end
        rep_count = rep_count + smp.elapsed_frames;    // wraps at 256
        if (rep_count > rep_delay)
        begin
            rep_count = '0;
            if (rep_delay > cfg_image.delay_floor)
                rep_delay = (rep_delay > cfg_image.delay_step) ?
                            rep_delay - cfg_image.delay_step : '0;
            return merged;
        end
        return '0;
    endfunction

    // Offer one sample with random idle cycles ahead of it; returns at the
    // edge of its transfer with s_tvalid still high.
    task automatic send_item(gar_pkg::sample_t smp, bit known,
                             logic [gar_pkg::BTN_W-1:0] pad);
        logic [gar_pkg::BTN_W-1:0] predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= smp.action;
        s_tdata  <= {smp.elapsed_frames, smp.stick_y, smp.stick_x, smp.raw_buttons};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = qualify_sample(smp);
        expected_pad.push_back(known ? pad : predicted);
        samples_sent++;
    endtask

    // Register write, only once every pending pad result has come back.
    task automatic write_reg(gar_pkg::cfg_reg_t idx, logic [gar_pkg::BTN_W-1:0] val);
        s_tvalid <= 1'b0;
        while (expected_pad.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            gar_pkg::REG_BUTTON_MASK:    cfg_image.button_mask    = val;
            gar_pkg::REG_LOW_THRESHOLD:  cfg_image.low_threshold  = val[gar_pkg::AXIS_W-1:0];
            gar_pkg::REG_HIGH_THRESHOLD: cfg_image.high_threshold = val[gar_pkg::AXIS_W-1:0];
            gar_pkg::REG_INITIAL_DELAY:  cfg_image.initial_delay  = val[gar_pkg::FRAME_W-1:0];
            gar_pkg::REG_DELAY_STEP:     cfg_image.delay_step     = val[gar_pkg::FRAME_W-1:0];
            gar_pkg::REG_DELAY_FLOOR:    cfg_image.delay_floor    = val[gar_pkg::FRAME_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_setting(gar_pkg::cfg_t c);
        write_reg(gar_pkg::REG_BUTTON_MASK,    c.button_mask);
        write_reg(gar_pkg::REG_LOW_THRESHOLD,  btn_t'(c.low_threshold));
        write_reg(gar_pkg::REG_HIGH_THRESHOLD, btn_t'(c.high_threshold));
        write_reg(gar_pkg::REG_INITIAL_DELAY,  btn_t'(c.initial_delay));
        write_reg(gar_pkg::REG_DELAY_STEP,     btn_t'(c.delay_step));
        write_reg(gar_pkg::REG_DELAY_FLOOR,    btn_t'(c.delay_floor));
        settings_applied++;
    endtask

    task automatic add_sample(logic act, logic [gar_pkg::BTN_W-1:0] raw, logic [7:0] sx,
                              logic [7:0] sy, logic [7:0] el, bit known,
                              logic [gar_pkg::BTN_W-1:0] pad);
        stim_row_t row;
        row = '{is_write: 1'b0, reg_sel: gar_pkg::REG_BUTTON_MASK, reg_val: '0,
                smp: '{act, raw, sx, sy, el}, known: known, pad: pad};
        directed_rows.push_back(row);
    endtask

    task automatic add_write(gar_pkg::cfg_reg_t idx, logic [gar_pkg::BTN_W-1:0] val);
        stim_row_t row;
        row = '{is_write: 1'b1, reg_sel: idx, reg_val: val,
                smp: '0, known: 1'b0, pad: '0};
        directed_rows.push_back(row);
    endtask

    // Centered most of the time, sometimes anywhere, sometimes pinned.
    function automatic logic [7:0] pick_axis();
        case ($urandom_range(0, 5))
            0:       return 8'($urandom_range(0, 255));
            1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            2:       return 8'($urandom_range(100, 156));
            default: return 8'd128;
        endcase
    endfunction

    // Press-and-hold bursts with random content, ended by release, clear or
    // a change of buttons; now and then a stray random sample.
    task automatic run_random(int n_items);
        gar_pkg::sample_t           smp;
        int                         sent;
        int                         hold_len;
        logic [gar_pkg::BTN_W-1:0]  pattern;
        logic [7:0]                 px;
        logic [7:0]                 py;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                smp.action         = $urandom_range(0, 1) ? gar_pkg::ACT_CLEAR :
                                                            gar_pkg::ACT_SAMPLE;
                smp.raw_buttons    = btn_t'($urandom());
                smp.stick_x        = 8'($urandom());
                smp.stick_y        = 8'($urandom());
                smp.elapsed_frames = 8'($urandom());
                send_item(smp, 1'b0, '0);
                sent++;
                continue;
            end
            case ($urandom_range(0, 3))
                0:       pattern = btn_t'(1) << $urandom_range(0, gar_pkg::BTN_W - 1);
                1:       pattern = '0;
                default: pattern = btn_t'($urandom());
            endcase
            px = pick_axis();
            py = pick_axis();
            hold_len = $urandom_range(1, 24);
            for (int k = 0; k < hold_len && sent < n_items; k++)
            begin
                smp.action         = gar_pkg::ACT_SAMPLE;
                smp.raw_buttons    = pattern;
                smp.stick_x        = px;
                smp.stick_y        = py;
                smp.elapsed_frames = ($urandom_range(0, 9) == 0) ?
                                     8'($urandom()) : 8'($urandom_range(0, 4));
                send_item(smp, 1'b0, '0);
                sent++;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    // release: no buttons, stick centered
                    smp = '{gar_pkg::ACT_SAMPLE, '0, 8'd128, 8'd128, 8'($urandom())};
                    send_item(smp, 1'b0, '0);
                    sent++;
                end
                4, 5, 6:
                begin
                    smp = '{gar_pkg::ACT_CLEAR, btn_t'($urandom()), 8'($urandom()),
                            8'($urandom()), 8'($urandom())};
                    send_item(smp, 1'b0, '0);
                    sent++;
                end
                default: ;  // next burst changes buttons while held
            endcase
        end
    endtask

    function automatic gar_pkg::cfg_t phase_setting(int p);
        gar_pkg::cfg_t c;
        case (p)
            0: c = gar_pkg::CFG_RESET;
            1: c = '{24'h000000, 8'd0,   8'd255, 8'd0,   8'd0,   8'd0};
            2: c = '{btn_t'($urandom()), 8'd255, 8'd0, 8'd255, 8'd255, 8'd255};
            3: c = '{24'hFFFFFF, 8'd100, 8'd156, 8'd20,  8'd3,   8'd4};
            4: c = '{btn_t'($urandom()), 8'($urandom_range(0, 127)),
                     8'($urandom_range(128, 255)), 8'($urandom_range(0, 30)),
                     8'($urandom_range(0, 8)), 8'($urandom_range(0, 10))};
            default: c = '{24'hFFFFFF, 8'd48, 8'd208, 8'd3, 8'd1, 8'd0};
        endcase
        return c;
    endfunction

    // Receiver: random back-pressure, plus a long hold-off when requested.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_served != stall_requests)
            begin
                stall_served++;
                m_tready <= 1'b0;
                for (int k = 0; k < LONG_STALL; k++)
                    @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Result checker: every pad transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pad.size() == 0)
            begin
                $error("pad_state: unexpected transfer, actual %06h", m_tdata);
                errors++;
            end
            else
            begin
                pad_want = expected_pad.pop_front();
                pads_checked++;
                if (m_tdata !== pad_want)
                begin
                    $error("pad_state: expected %06h, actual %06h", pad_want, m_tdata);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pad results outstanding",
                     cycles, expected_pad.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        // Directed part, default registers first
        add_sample(gar_pkg::ACT_CLEAR,  24'h000000, 8'd128, 8'd128, 8'd0,   1'b1, 24'h000000);
        add_sample(gar_pkg::ACT_SAMPLE, 24'h000000, 8'd128, 8'd128, 8'd0,   1'b1, 24'h000000);
        // fresh press, elapsed ignored
        add_sample(gar_pkg::ACT_SAMPLE, 24'hFFFFFF, 8'd128, 8'd128, 8'd255, 1'b1, 24'hFFFFFF);
        add_sample(gar_pkg::ACT_SAMPLE, 24'hFFFFFF, 8'd128, 8'd128, 8'd8,   1'b0, '0);
        add_sample(gar_pkg::ACT_SAMPLE, 24'hFFFFFF, 8'd128, 8'd128, 8'd1,   1'b0, '0);
        add_sample(gar_pkg::ACT_SAMPLE, 24'hFFFFFF, 8'd128, 8'd128, 8'd255, 1'b0, '0);
        add_sample(gar_pkg::ACT_SAMPLE, 24'hFFFFFF, 8'd128, 8'd128, 8'd3,   1'b0, '0);
        // count wraps past 256 and stays under the delay
        add_sample(gar_pkg::ACT_SAMPLE, 24'hFFFFFF, 8'd128, 8'd128, 8'd254, 1'b0, '0);
        // clear ignores every other field
        add_sample(gar_pkg::ACT_CLEAR,  24'hFFFFFF, 8'd0,   8'd0,   8'd255, 1'b1, 24'h000000);
        // stick extremes and threshold edges
        add_sample(gar_pkg::ACT_SAMPLE, 24'h000000, 8'd0,   8'd0,   8'd0,   1'b1, 24'h000090);
        add_sample(gar_pkg::ACT_CLEAR,  24'h000000, 8'd128, 8'd128, 8'd0,   1'b1, 24'h000000);
        add_sample(gar_pkg::ACT_SAMPLE, 24'h000000, 8'd255, 8'd255, 8'd0,   1'b1, 24'h000060);
        add_sample(gar_pkg::ACT_SAMPLE, 24'h000000, 8'd128, 8'd128, 8'd0,   1'b1, 24'h000000);
        add_sample(gar_pkg::ACT_SAMPLE, 24'h000000, 8'd48,  8'd208, 8'd0,   1'b1, 24'h0000C0);
        add_sample(gar_pkg::ACT_SAMPLE, 24'h000000, 8'd49,  8'd207, 8'd0,   1'b1, 24'h000000);
        add_sample(gar_pkg::ACT_SAMPLE, 24'h000000, 8'd208, 8'd48,  8'd0,   1'b1, 24'h000030);
        add_sample(gar_pkg::ACT_SAMPLE, 24'h000000, 8'd128, 8'd128, 8'd0,   1'b1, 24'h000000);
        // overlapping thresholds, big step so the delay saturates at zero
        add_write(gar_pkg::REG_BUTTON_MASK,    24'h00000F);
        add_write(gar_pkg::REG_LOW_THRESHOLD,  24'd200);
        add_write(gar_pkg::REG_HIGH_THRESHOLD, 24'd100);
        add_write(gar_pkg::REG_INITIAL_DELAY,  24'd5);
        add_write(gar_pkg::REG_DELAY_STEP,     24'd255);
        add_write(gar_pkg::REG_DELAY_FLOOR,    24'd0);
        add_sample(gar_pkg::ACT_SAMPLE, 24'hFFFFFF, 8'd150, 8'd150, 8'd0,   1'b1, 24'h0000FF);
        add_sample(gar_pkg::ACT_SAMPLE, 24'hFFFFFF, 8'd150, 8'd150, 8'd6,   1'b0, '0);
        add_sample(gar_pkg::ACT_SAMPLE, 24'hFFFFFF, 8'd150, 8'd150, 8'd1,   1'b0, '0);
        add_sample(gar_pkg::ACT_SAMPLE, 24'hFFFFFF, 8'd150, 8'd150, 8'd0,   1'b0, '0);
        add_sample(gar_pkg::ACT_CLEAR,  24'h000000, 8'd128, 8'd128, 8'd0,   1'b1, 24'h000000);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 38;
        recv_idle_pct = 57;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
                write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
            else
                send_item(directed_rows[i].smp, directed_rows[i].known, directed_rows[i].pad);
        end

        for (int p = 0; p < 6; p++)
        begin
            if (p == 2)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 38;
            end
            else if (p == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_setting(phase_setting(p));
            // sender keeps streaming into a blocked output to fill both stages
            if (p == 4)
                stall_requests++;
            run_random(ITEMS_PER_SET);
        end
        s_tvalid <= 1'b0;

        while (expected_pad.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d samples (%0d table rows) over %0d register settings,",
                 samples_sent, directed_rows.size(), settings_applied);
        $display("%0d pad results checked, %0d errors", pads_checked, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/gar_pkg.sv
rtl/core/gar_cfg_regs.sv
rtl/core/gar_merge.sv
rtl/core/gar_repeat.sv
rtl/core/gamepad_autorepeat_qualifier.sv
rtl/core/gar_checker.sv
tb/sv/gamepad_autorepeat_qualifier_tb.sv
